// ===== hdl/bdq_pkg.sv =====
// Package for the bounded double-ended queue.
// Holds the storage depth, field widths, request codes and shared types.
// Used by the channel interfaces, the top level and the checker.
package bdq_pkg;

    // Built storage depth and the widths that follow from it.
    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Field widths fixed by the transaction format.
    localparam int WORD_W = 32;
    localparam int CNT_W  = 5;
    localparam int REQ_W  = 3;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [REQ_W-1:0]         req_t;

    // Request codes.
    localparam req_t REQ_INS_FRONT = 3'd0;
    localparam req_t REQ_INS_REAR  = 3'd1;
    localparam req_t REQ_DEL_FRONT = 3'd2;
    localparam req_t REQ_DEL_REAR  = 3'd3;
    localparam req_t REQ_QUERY     = 3'd4;

    // Word reported for both ends while the queue is empty.
    localparam word_t EMPTY_WORD = -32'sd1;

    // Capacity after reset.
    localparam cnt_t CAP_RESET = cnt_t'(DEPTH);

endpackage

// ===== hdl/bdq_if.sv =====
// Valid/ready channel interfaces for the request and result transactions.
// Depends on bdq_pkg for the payload types.
interface bdq_req_if;
    logic          valid;
    logic          ready;
    bdq_pkg::req_t  req_type;
    bdq_pkg::word_t value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface bdq_rsp_if;
    logic           valid;
    logic           ready;
    logic           ok;
    bdq_pkg::word_t front_word;
    bdq_pkg::word_t rear_word;
    logic           is_empty;
    logic           is_full;
    bdq_pkg::cnt_t  occupancy;

    modport source (output valid, output ok, output front_word, output rear_word,
                    output is_empty, output is_full, output occupancy, input ready);
    modport sink   (input valid, input ok, input front_word, input rear_word,
                    input is_empty, input is_full, input occupancy, output ready);
endinterface

// ===== hdl/bounded_double_ended_queue.sv =====
// Bounded double-ended queue of signed 32-bit words in a 16-entry ring memory.
// Sequence: an accepted request updates the pointers and count; in ST_READ both
// ends are read into registers, and in ST_LOAD the result register is loaded once free.
// Flow: a new request is taken only after the previous result has been loaded into
// the result register; an untaken result holds input off.
// Reset: the queue is empty, the capacity is 16 and no result is pending;
// the ring contents are not cleared. A capacity write also empties the queue.
module bounded_double_ended_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  bdq_pkg::cnt_t     cfg_wr_data,
    bdq_req_if.sink           req,
    bdq_rsp_if.source         rsp
);
    import bdq_pkg::*;

    // Sequencer codes.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0] state_reg, state_next;

    cnt_t  capacity_reg;
    idx_t  head_reg, head_next;
    idx_t  tail_reg, tail_next;
    cnt_t  count_reg, count_next;
    logic  ok_reg, ok_next;

    // Result register.
    logic  rsp_valid_reg;
    logic  rsp_ok_reg;
    word_t rsp_front_reg;
    word_t rsp_rear_reg;
    logic  rsp_empty_reg;
    logic  rsp_full_reg;
    cnt_t  rsp_occ_reg;

    // Ring memory and its registered read data.
    word_t ring_mem [DEPTH];
    word_t front_rd_reg;
    word_t rear_rd_reg;
    logic  mem_we;
    idx_t  mem_wr_idx;

    logic  req_fire;
    logic  load_rsp;
    cnt_t  cap_eff;
    cnt_t  cfg_cap_eff;
    cnt_t  head_ext;
    cnt_t  tail_ext;
    logic  is_full_now;
    logic  is_empty_now;
    idx_t  head_dec;
    idx_t  head_inc;
    idx_t  tail_dec;
    idx_t  tail_inc;

    // Effective capacity: zero acts as one, anything above the depth as the depth.
    function automatic cnt_t clamp_cap(input cnt_t cap);
        cnt_t res;
        res = cap;
        if (cap == '0)
            res = cnt_t'(1);
        else if (cap > cnt_t'(DEPTH))
            res = cnt_t'(DEPTH);
        return res;
    endfunction

    assign cap_eff     = clamp_cap(capacity_reg);
    assign cfg_cap_eff = clamp_cap(cfg_wr_data);

    // Requests are taken only while the sequencer is idle.
    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign load_rsp  = (state_reg == ST_LOAD) && (!rsp_valid_reg || rsp.ready);

    // Wrapping index steps at the effective capacity.
    assign head_ext     = cnt_t'(head_reg);
    assign tail_ext     = cnt_t'(tail_reg);
    assign is_full_now  = (count_reg >= cap_eff);
    assign is_empty_now = (count_reg == '0);
    assign head_dec = (head_ext == '0 || head_ext >= cap_eff) ? idx_t'(cap_eff - cnt_t'(1))
                                                              : idx_t'(head_ext - cnt_t'(1));
    assign head_inc = (head_ext + cnt_t'(1) >= cap_eff) ? '0 : idx_t'(head_ext + cnt_t'(1));
    assign tail_dec = (tail_ext == '0 || tail_ext >= cap_eff) ? idx_t'(cap_eff - cnt_t'(1))
                                                              : idx_t'(tail_ext - cnt_t'(1));
    assign tail_inc = (tail_ext + cnt_t'(1) >= cap_eff) ? '0 : idx_t'(tail_ext + cnt_t'(1));

    // Pointer and count update for the accepted request.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        ok_next    = 1'b0;
        mem_we     = 1'b0;
        mem_wr_idx = head_dec;
        unique case (req.req_type)
            REQ_INS_FRONT:
            begin
                if (!is_full_now)
                begin
                    head_next  = head_dec;
                    count_next = count_reg + cnt_t'(1);
                    ok_next    = 1'b1;
                    mem_we     = req_fire;
                end
            end
            REQ_INS_REAR:
            begin
                mem_wr_idx = tail_inc;
                if (!is_full_now)
                begin
                    tail_next  = tail_inc;
                    count_next = count_reg + cnt_t'(1);
                    ok_next    = 1'b1;
                    mem_we     = req_fire;
                end
            end
            REQ_DEL_FRONT:
            begin
                if (!is_empty_now)
                begin
                    head_next  = head_inc;
                    count_next = count_reg - cnt_t'(1);
                    ok_next    = 1'b1;
                end
            end
            REQ_DEL_REAR:
            begin
                if (!is_empty_now)
                begin
                    tail_next  = tail_dec;
                    count_next = count_reg - cnt_t'(1);
                    ok_next    = 1'b1;
                end
            end
            REQ_QUERY:
            begin
                ok_next = 1'b1;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    // Sequencer: accept, read both ends, then hand over to the result register.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (load_rsp)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state: sequencer, capacity, pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            capacity_reg <= CAP_RESET;
            head_reg     <= '0;
            tail_reg     <= idx_t'(clamp_cap(CAP_RESET) - cnt_t'(1));
            count_reg    <= '0;
            ok_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
                head_reg     <= '0;
                tail_reg     <= idx_t'(cfg_cap_eff - cnt_t'(1));
                count_reg    <= '0;
            end
            else if (req_fire)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
                ok_reg    <= ok_next;
            end
        end
    end

    // Ring memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[mem_wr_idx] <= req.value;
        front_rd_reg <= ring_mem[head_reg];
        rear_rd_reg  <= ring_mem[tail_reg];
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (load_rsp)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    // Result payload, loaded once the read data has settled.
    always_ff @(posedge clk)
    begin
        if (load_rsp)
        begin
            rsp_ok_reg    <= ok_reg;
            rsp_front_reg <= is_empty_now ? EMPTY_WORD : front_rd_reg;
            rsp_rear_reg  <= is_empty_now ? EMPTY_WORD : rear_rd_reg;
            rsp_empty_reg <= is_empty_now;
            rsp_full_reg  <= is_full_now;
            rsp_occ_reg   <= count_reg;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.ok         = rsp_ok_reg;
    assign rsp.front_word = rsp_front_reg;
    assign rsp.rear_word  = rsp_rear_reg;
    assign rsp.is_empty   = rsp_empty_reg;
    assign rsp.is_full    = rsp_full_reg;
    assign rsp.occupancy  = rsp_occ_reg;

endmodule

// ===== hdl/bdq_checker.sv =====
// Port-level checker for the bounded double-ended queue, with its bind.
// Depends on bdq_pkg; watches only the ports of bounded_double_ended_queue.
module bdq_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           rsp_valid,
    input  logic           rsp_ready,
    input  logic           rsp_ok,
    input  bdq_pkg::word_t rsp_front_word,
    input  bdq_pkg::word_t rsp_rear_word,
    input  logic           rsp_is_empty,
    input  logic           rsp_is_full,
    input  bdq_pkg::cnt_t  rsp_occupancy
);
    import bdq_pkg::*;

    // An empty result reports no entries and the empty word at both ends.
    a_empty_view: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_is_empty) |->
            (rsp_occupancy == '0 && rsp_front_word == EMPTY_WORD
             && rsp_rear_word == EMPTY_WORD))
        else $error("empty result with entries or a stale end word");

    // The occupancy agrees with the empty flag.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_is_empty) |-> (rsp_occupancy != '0))
        else $error("non-empty result with zero occupancy");

    // Capacity is at least one, so the queue is never full and empty at once,
    // and never holds more than the built depth.
    a_full_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (!(rsp_is_full && rsp_is_empty) && rsp_occupancy <= cnt_t'(DEPTH)))
        else $error("inconsistent full flag or occupancy beyond depth");

    // A stalled result holds until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_ok) && $stable(rsp_front_word)
             && $stable(rsp_rear_word) && $stable(rsp_is_empty)
             && $stable(rsp_is_full) && $stable(rsp_occupancy)))
        else $error("stalled result changed");

endmodule

bind bounded_double_ended_queue bdq_checker u_bdq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_ok         (rsp.ok),
    .rsp_front_word (rsp.front_word),
    .rsp_rear_word  (rsp.rear_word),
    .rsp_is_empty   (rsp.is_empty),
    .rsp_is_full    (rsp.is_full),
    .rsp_occupancy  (rsp.occupancy)
);

// ===== tb/bounded_double_ended_queue_tb.sv =====
// Self-checking testbench for the bounded double-ended queue.
// Predicts every result from a shadow copy of the ring and its pointers.
// Depends on bdq_pkg and the channel interfaces in bdq_if.
module bounded_double_ended_queue_tb;
    import bdq_pkg::*;

    // Request codes with no defined operation.
    localparam req_t REQ_SPARE_5 = 3'd5;
    localparam req_t REQ_SPARE_6 = 3'd6;
    localparam req_t REQ_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS    = 800;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SETTLE_CYCLES   = 8;
    localparam int RUN_LIMIT       = 20 * 400000;

    typedef struct {
        logic  ok;
        word_t front_word;
        word_t rear_word;
        logic  is_empty;
        logic  is_full;
        cnt_t  occupancy;
    } deque_status_t;

    typedef enum { MIX_FILL, MIX_DRAIN, MIX_BALANCED } traffic_mix_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    cnt_t cfg_wr_data;

    bdq_req_if req_ch ();
    bdq_rsp_if rsp_ch ();

    // Shadow state of the queue.
    word_t       model_ring [DEPTH];
    int unsigned model_head;
    int unsigned model_tail;
    int unsigned model_count;
    cnt_t        model_cap_reg;

    deque_status_t pending_status [$];
    int            mismatch_count;

    // Sender and receiver pacing controls.
    bit            sender_gaps;
    int            burst_left;
    bit            rx_free;
    int            rx_hold_cycles;
    logic [15:0]   rx_pattern;
    int            rx_tick;

    bounded_double_ended_queue dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // A capacity of zero behaves as one, and anything above the depth as the depth.
    function automatic int unsigned live_capacity();
        if (model_cap_reg == 0)
            return 1;
        if (model_cap_reg > DEPTH)
            return DEPTH;
        return model_cap_reg;
    endfunction

    // Programming the capacity empties the queue; the words stay but are unreachable.
    function automatic void program_capacity(cnt_t cap);
        model_cap_reg = cap;
        model_head    = 0;
        model_tail    = live_capacity() - 1;
        model_count   = 0;
    endfunction

    // Applies one request to the shadow queue and returns the state that follows.
    function automatic deque_status_t apply_deque_request(req_t code, word_t word);
        deque_status_t st;
        int unsigned   cap;
        logic          full_now;
        logic          empty_now;
        cap       = live_capacity();
        full_now  = model_count >= cap;
        empty_now = model_count == 0;
        st.ok     = 1'b0;
        case (code)
            REQ_INS_FRONT:
                if (!full_now)
                begin
                    model_head = (model_head == 0 || model_head >= cap) ? cap - 1
                                                                        : model_head - 1;
                    model_ring[model_head] = word;
                    model_count++;
                    st.ok = 1'b1;
                end
            REQ_INS_REAR:
                if (!full_now)
                begin
                    model_tail = (model_tail + 1 >= cap) ? 0 : model_tail + 1;
                    model_ring[model_tail] = word;
                    model_count++;
                    st.ok = 1'b1;
                end
            REQ_DEL_FRONT:
                if (!empty_now)
                begin
                    model_head = (model_head + 1 >= cap) ? 0 : model_head + 1;
                    model_count--;
                    st.ok = 1'b1;
                end
            REQ_DEL_REAR:
                if (!empty_now)
                begin
                    model_tail = (model_tail == 0 || model_tail >= cap) ? cap - 1
                                                                        : model_tail - 1;
                    model_count--;
                    st.ok = 1'b1;
                end
            REQ_QUERY:
                st.ok = 1'b1;
            default:
                st.ok = 1'b0;
        endcase
        st.is_empty   = (model_count == 0);
        st.front_word = st.is_empty ? EMPTY_WORD : model_ring[model_head];
        st.rear_word  = st.is_empty ? EMPTY_WORD : model_ring[model_tail];
        st.is_full    = (model_count >= cap);
        st.occupancy  = cnt_t'(model_count);
        return st;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Compares one result transaction with the oldest prediction.
    task automatic check_status(input deque_status_t got);
        deque_status_t want;
        if (pending_status.size() == 0)
        begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none, actual occupancy %0d",
                     $time, got.occupancy);
        end
        else
        begin
            want = pending_status[0];
            pending_status.delete(0);
            compare_field("ok", want.ok, got.ok);
            compare_field("front_word", want.front_word, got.front_word);
            compare_field("rear_word", want.rear_word, got.rear_word);
            compare_field("is_empty", want.is_empty, got.is_empty);
            compare_field("is_full", want.is_full, got.is_full);
            compare_field("occupancy", want.occupancy, got.occupancy);
        end
    endtask

    // Monitor: tracks capacity writes, checks results and predicts accepted requests.
    always @(posedge clk or negedge rst_n)
    begin
        deque_status_t got;
        if (!rst_n)
        begin
            foreach (model_ring[i])
                model_ring[i] = '0;
            program_capacity(CAP_RESET);
            pending_status.delete();
        end
        else
        begin
            if (cfg_wr_en)
                program_capacity(cfg_wr_data);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.ok         = rsp_ch.ok;
                got.front_word = rsp_ch.front_word;
                got.rear_word  = rsp_ch.rear_word;
                got.is_empty   = rsp_ch.is_empty;
                got.is_full    = rsp_ch.is_full;
                got.occupancy  = rsp_ch.occupancy;
                check_status(got);
            end
            if (req_ch.valid && req_ch.ready)
                pending_status.insert(pending_status.size(),
                                      apply_deque_request(req_ch.req_type, req_ch.value));
        end
    end

    // Receiver: a long hold-off when asked, otherwise free-running or a rotating pattern.
    initial
    begin
        rsp_ch.ready = 1'b0;
        rx_pattern   = 16'hA5C3;
        rx_tick      = 0;
        forever
        begin
            @(negedge clk);
            rx_tick++;
            if (rx_hold_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rx_hold_cycles--;
            end
            else if (rx_free)
                rsp_ch.ready <= 1'b1;
            else
            begin
                if (rx_tick % 29 == 0)
                    rx_pattern = 16'($urandom) | 16'h0001;
                rsp_ch.ready <= rx_pattern[0];
                rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
            end
        end
    end

    // Inserts a gap of idle cycles at the end of each burst.
    task automatic pace_sender();
        int gap;
        if (sender_gaps)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 6);
                repeat (gap) @(negedge clk) req_ch.valid <= 1'b0;
                burst_left = $urandom_range(1, 12);
            end
            else
                burst_left--;
        end
    endtask

    // Offers one request and waits until it is accepted.
    task automatic send_request(input req_t code, input word_t word);
        @(negedge clk);
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= code;
        req_ch.value    <= word;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pace_sender();
    endtask

    // Holds the sender off until every predicted result has been seen.
    task automatic wait_for_results();
        @(negedge clk) req_ch.valid <= 1'b0;
        while (pending_status.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_capacity(input cnt_t cap);
        wait_for_results();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(negedge clk) cfg_wr_en <= 1'b0;
    endtask

    // Chooses a request with a bias towards inserts or deletes, plus some queries and stray codes.
    task automatic pick_request(input traffic_mix_t mix, output req_t code,
                                output word_t word);
        int roll;
        int insert_pct;
        roll       = $urandom_range(0, 99);
        insert_pct = (mix == MIX_FILL) ? 75 : (mix == MIX_DRAIN) ? 25 : 50;
        if (roll < 3)
        begin
            case ($urandom_range(0, 2))
                0: code = REQ_SPARE_5;
                1: code = REQ_SPARE_6;
                default: code = REQ_SPARE_7;
            endcase
        end
        else if (roll < 8)
            code = REQ_QUERY;
        else if ($urandom_range(0, 99) < insert_pct)
            code = $urandom_range(0, 1) ? REQ_INS_REAR : REQ_INS_FRONT;
        else
            code = $urandom_range(0, 1) ? REQ_DEL_REAR : REQ_DEL_FRONT;
        case ($urandom_range(0, 15))
            0: word = word_t'(32'h7FFF_FFFF);
            1: word = word_t'(32'h8000_0000);
            2: word = '0;
            3: word = EMPTY_WORD;
            default: word = word_t'($urandom);
        endcase
    endtask

    // Requests straight after reset: queries, deletes and stray codes on an empty queue.
    task automatic test_reset_state();
        send_request(REQ_QUERY, '0);
        send_request(REQ_DEL_FRONT, word_t'(32'h1234_5678));
        send_request(REQ_DEL_REAR, '0);
        send_request(REQ_SPARE_5, word_t'(32'hDEAD_BEEF));
        send_request(REQ_SPARE_7, '0);
    endtask

    // Extreme words pushed at both ends, then taken off both ends.
    task automatic test_both_ends();
        send_request(REQ_INS_FRONT, word_t'(32'h7FFF_FFFF));
        send_request(REQ_INS_REAR, word_t'(32'h8000_0000));
        send_request(REQ_INS_FRONT, '0);
        send_request(REQ_INS_REAR, EMPTY_WORD);
        send_request(REQ_QUERY, word_t'(32'h5555_AAAA));
        send_request(REQ_DEL_FRONT, '0);
        send_request(REQ_DEL_REAR, '0);
        send_request(REQ_DEL_FRONT, '0);
        send_request(REQ_DEL_REAR, '0);
    endtask

    // A zero capacity acting as one, and a capacity of two filled past its limit.
    task automatic test_capacity_limits();
        write_capacity(5'd0);
        send_request(REQ_INS_REAR, word_t'(32'd11));
        send_request(REQ_INS_FRONT, word_t'(32'd22));
        send_request(REQ_SPARE_6, word_t'(32'd7));
        write_capacity(5'd2);
        send_request(REQ_INS_FRONT, word_t'(32'd33));
        send_request(REQ_INS_FRONT, word_t'(32'd44));
        send_request(REQ_INS_REAR, word_t'(32'd55));
        send_request(REQ_DEL_REAR, '0);
        send_request(REQ_DEL_REAR, '0);
    endtask

    // The receiver holds off while the sender keeps offering, so the input stalls.
    task automatic test_backpressure();
        req_t  code;
        word_t word;
        write_capacity(5'd8);
        sender_gaps    = 1'b0;
        rx_hold_cycles = HOLD_OFF_CYCLES;
        for (int i = 0; i < 30; i++)
        begin
            pick_request((i < 15) ? MIX_FILL : MIX_DRAIN, code, word);
            send_request(code, word);
        end
        sender_gaps = 1'b1;
        wait_for_results();
    endtask

    // Phases of random traffic, each at its own capacity and pacing.
    task automatic test_random_traffic();
        cnt_t         lead_caps [4];
        cnt_t         cap;
        int           sent;
        int           phase;
        int           phase_len;
        int           mix_left;
        int           roll;
        traffic_mix_t mix;
        req_t         code;
        word_t        word;
        lead_caps = '{5'd1, 5'd16, 5'd31, 5'd0};
        sent      = 0;
        phase     = 0;
        mix       = MIX_BALANCED;
        while (sent < RANDOM_ITEMS)
        begin
            if (phase < 4)
                cap = lead_caps[phase];
            else
            begin
                roll = $urandom_range(0, 9);
                if (roll < 6)
                    cap = cnt_t'($urandom_range(1, 8));
                else if (roll == 6)
                    cap = 5'd16;
                else if (roll == 7)
                    cap = 5'd0;
                else if (roll == 8)
                    cap = cnt_t'($urandom_range(17, 31));
                else
                    cap = cnt_t'($urandom_range(9, 15));
            end
            write_capacity(cap);
            rx_free     = ($urandom_range(0, 3) == 0);
            sender_gaps = ($urandom_range(0, 3) != 0);
            phase_len   = $urandom_range(20, 60);
            mix_left    = 0;
            for (int i = 0; i < phase_len; i++)
            begin
                if (mix_left == 0)
                begin
                    mix      = traffic_mix_t'($urandom_range(0, 2));
                    mix_left = $urandom_range(6, 24);
                end
                mix_left--;
                pick_request(mix, code, word);
                send_request(code, word);
                sent++;
            end
            phase++;
        end
        rx_free     = 1'b0;
        sender_gaps = 1'b1;
    endtask

    // Main sequence.
    initial
    begin
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = CAP_RESET;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_QUERY;
        req_ch.value    = '0;
        sender_gaps     = 1'b1;
        burst_left      = 0;
        rx_free         = 1'b0;
        rx_hold_cycles  = 0;
        mismatch_count  = 0;
        repeat (10) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_reset_state();
        test_both_ends();
        test_capacity_limits();
        test_backpressure();
        test_random_traffic();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && pending_status.size() == 0)
            $display("bounded_double_ended_queue_tb: clean");
        else
            $display("bounded_double_ended_queue_tb: errors");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #(RUN_LIMIT);
        $display("bounded_double_ended_queue_tb: errors");
        $finish;
    end

endmodule
